// ===== rtl/core/pulse_rate_slope_detector_unit_macros.svh =====
// assertion macros of the pulse rate slope detector checker
`ifndef PULSE_RATE_SLOPE_DETECTOR_UNIT_MACROS_SVH
`define PULSE_RATE_SLOPE_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, reset masks the check
`define PRSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse rate slope detector check failed");

// next-cycle implication, reset masks the check
`define PRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse rate slope detector check failed");

`endif

// ===== rtl/core/prsd_pkg.sv =====
// shared types, constants and register codes of the pulse rate slope detector
package prsd_pkg;

    // defaults for top level parameters
    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // register field widths
    localparam int THRESH_W = 12;
    localparam int TPS_W    = 10;
    localparam int RATE_W   = 16;
    localparam int TICKS_W  = 16;
    localparam int SUM_W    = 32;

    // config port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SLOPE_THRESHOLD      = 3'd0,
        REG_TICKS_PER_SECOND     = 3'd1,
        REG_MIN_VALID_BPM        = 3'd2,
        REG_MAX_VALID_BPM        = 3'd3,
        REG_AVERAGE_WINDOW_TICKS = 3'd4
    } cfg_index_t;

    // register reset values
    localparam logic [THRESH_W-1:0] SLOPE_THRESHOLD_RST      = 12'd120;
    localparam logic [TPS_W-1:0]    TICKS_PER_SECOND_RST     = 10'd100;
    localparam logic [RATE_W-1:0]   MIN_VALID_BPM_RST        = 16'd20;
    localparam logic [RATE_W-1:0]   MAX_VALID_BPM_RST        = 16'd300;
    localparam logic [TICKS_W-1:0]  AVERAGE_WINDOW_TICKS_RST = 16'd1500;

    // rate scaling: bpm = (2*60*tps + ticks) / (2*ticks)
    localparam int SCALE_W = 7;
    localparam logic [SCALE_W-1:0] RATE_SCALE = 7'd120;
    localparam int NUM_W = 18;

    // shared divider
    localparam int DIVIDEND_W    = 32;
    localparam int DIVISOR_W     = 17;
    localparam int DIV_STEP_W    = 6;
    localparam logic [DIV_STEP_W-1:0] BPM_DIV_STEPS = 6'd18;
    localparam logic [DIV_STEP_W-1:0] AVG_DIV_STEPS = 6'd32;

    // result beat layout, lowest bit first
    localparam int OUT_LED_ON_BIT        = 0;
    localparam int OUT_BEAT_DONE_BIT     = 1;
    localparam int OUT_BPM_LSB           = 2;
    localparam int OUT_BPM_VALID_BIT     = 18;
    localparam int OUT_AVERAGE_DONE_BIT  = 19;
    localparam int OUT_AVERAGE_BPM_LSB   = 20;
    localparam int OUT_AVERAGE_EMPTY_BIT = 36;
    localparam int OUT_FIELD_BITS        = 37;
    localparam int OUT_TDATA_W           = 40;

    typedef struct packed {
        logic [THRESH_W-1:0] slope_threshold;
        logic [TPS_W-1:0]    ticks_per_second;
        logic [RATE_W-1:0]   min_valid_bpm;
        logic [RATE_W-1:0]   max_valid_bpm;
        logic [TICKS_W-1:0]  average_window_ticks;
    } cfg_t;

    // one classified tick as passed from front to back
    typedef struct packed {
        logic measuring;
    } item_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              average_empty;
        logic [RATE_W-1:0] average_bpm;
        logic              average_done;
        logic              bpm_valid;
        logic [RATE_W-1:0] bpm;
        logic              beat_done;
        logic              led_on;
    } result_t;

endpackage

// ===== rtl/core/prsd_front.sv =====
// front end: slope test on each sample and measuring flag toggle
module prsd_front #(
    parameter int SAMPLE_BITS = prsd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [prsd_pkg::THRESH_W-1:0]      slope_threshold,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [SAMPLE_BITS-1:0]             sample,
    output logic                               push,
    output prsd_pkg::item_t                    push_item,
    input  logic                               queue_full
);

    localparam int CMP_W =
        (SAMPLE_BITS > prsd_pkg::THRESH_W ? SAMPLE_BITS : prsd_pkg::THRESH_W) + 1;

    logic [SAMPLE_BITS-1:0] prev_sample_reg, prev_sample_next;
    logic                   rise_seen_reg, rise_seen_next;
    logic                   measuring_reg, measuring_next;
    logic [CMP_W-1:0]       prev_ext, smp_ext, thr_ext;
    logic                   rise, fall;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // slope classification against the previous sample
    always_comb
    begin
        prev_ext = CMP_W'(prev_sample_reg);
        smp_ext  = CMP_W'(sample);
        thr_ext  = CMP_W'(slope_threshold);
        rise     = (prev_ext + thr_ext) < smp_ext;
        fall     = (prev_ext > (smp_ext + thr_ext)) && rise_seen_reg;
    end

    // state update per accepted beat
    always_comb
    begin
        prev_sample_next = prev_sample_reg;
        rise_seen_next   = rise_seen_reg;
        measuring_next   = measuring_reg;
        if (push)
        begin
            prev_sample_next = sample;
            if (rise)
            begin
                rise_seen_next = 1'b1;
            end
            else if (fall)
            begin
                measuring_next = !measuring_reg;
                rise_seen_next = 1'b0;
            end
        end
        push_item.measuring = measuring_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            rise_seen_reg   <= 1'b0;
            measuring_reg   <= 1'b0;
        end
        else
        begin
            prev_sample_reg <= prev_sample_next;
            rise_seen_reg   <= rise_seen_next;
            measuring_reg   <= measuring_next;
        end
    end

endmodule

// ===== rtl/core/prsd_queue.sv =====
// small fifo between front end and back end
module prsd_queue #(
    parameter int DEPTH = prsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  prsd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output prsd_pkg::item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    prsd_pkg::item_t  entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entries_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/prsd_divider.sv =====
// shared restoring divider, one quotient bit per cycle
module prsd_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  prsd_pkg::div_req_t req,
    output prsd_pkg::div_rsp_t rsp
);

    logic [prsd_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [prsd_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [prsd_pkg::DIVISOR_W-1:0]  div_reg, div_next;
    logic [prsd_pkg::DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [prsd_pkg::DIVISOR_W:0]    trial;
    logic                            fits;

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[prsd_pkg::DIVIDEND_W-1]};
        fits      = trial >= {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? prsd_pkg::DIVISOR_W'(trial - {1'b0, div_reg})
                            : prsd_pkg::DIVISOR_W'(trial);
            quo_next = {quo_reg[prsd_pkg::DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == prsd_pkg::DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== rtl/core/prsd_back.sv =====
// back end: period and window counters, rate and mean, result register
module prsd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  prsd_pkg::cfg_t     cfg,
    input  logic               q_not_empty,
    input  prsd_pkg::item_t    q_item,
    output logic               q_pop,
    output prsd_pkg::div_req_t div_req,
    input  prsd_pkg::div_rsp_t div_rsp,
    output logic               out_valid,
    input  logic               out_ready,
    output prsd_pkg::result_t  out_result
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BPM   = 6'b000010,
        ST_CLOSE = 6'b000100,
        ST_AVG   = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_SPARE = 6'b100000
    } back_state_t;

    localparam logic [prsd_pkg::TICKS_W-1:0] TICKS_MAX = '1;
    localparam logic [prsd_pkg::SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [prsd_pkg::RATE_W-1:0]  RATE_MAX  = '1;

    back_state_t                   state_reg, state_next;
    logic [prsd_pkg::TICKS_W-1:0]  window_reg, window_next;
    logic [prsd_pkg::TICKS_W-1:0]  period_reg, period_next;
    logic                          was_meas_reg, was_meas_next;
    logic [prsd_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [prsd_pkg::TICKS_W-1:0]  count_reg, count_next;
    logic [prsd_pkg::RATE_W-1:0]   avg_reg, avg_next;
    prsd_pkg::result_t             res_reg, res_next;
    prsd_pkg::result_t             out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic [prsd_pkg::NUM_W-1:0]    rate_num;
    logic [prsd_pkg::RATE_W-1:0]   quo_sat;
    logic [prsd_pkg::SUM_W:0]      sum_wide;

    assign q_pop      = (state_reg == ST_IDLE) && q_not_empty;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // rounding numerator and saturated quotient
    always_comb
    begin
        rate_num = prsd_pkg::NUM_W'(cfg.ticks_per_second * prsd_pkg::RATE_SCALE)
                 + prsd_pkg::NUM_W'(period_reg);
        quo_sat  = (|div_rsp.quotient[prsd_pkg::DIVIDEND_W-1:prsd_pkg::RATE_W])
                 ? RATE_MAX : div_rsp.quotient[prsd_pkg::RATE_W-1:0];
        sum_wide = {1'b0, sum_reg} + (prsd_pkg::SUM_W + 1)'(quo_sat);
    end

    // sequencer for one tick
    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        period_next    = period_reg;
        was_meas_next  = was_meas_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        avg_next       = avg_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_req        = '0;

        // result slot drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    window_next = (window_reg == TICKS_MAX) ? window_reg
                                                            : window_reg + 1'b1;
                    res_next        = '0;
                    res_next.led_on = q_item.measuring;
                    if (q_item.measuring)
                    begin
                        was_meas_next = 1'b1;
                        period_next   = (period_reg == TICKS_MAX) ? period_reg
                                                                  : period_reg + 1'b1;
                        state_next    = ST_CLOSE;
                    end
                    else if (was_meas_reg)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {rate_num,
                            (prsd_pkg::DIVIDEND_W - prsd_pkg::NUM_W)'(0)};
                        div_req.divisor  = {period_reg, 1'b0};
                        div_req.steps    = prsd_pkg::BPM_DIV_STEPS;
                        state_next       = ST_BPM;
                    end
                    else
                    begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_BPM:
            begin
                if (div_rsp.done)
                begin
                    res_next.bpm       = quo_sat;
                    res_next.beat_done = 1'b1;
                    res_next.bpm_valid = (quo_sat >= cfg.min_valid_bpm)
                                      && (quo_sat <= cfg.max_valid_bpm);
                    sum_next      = sum_wide[prsd_pkg::SUM_W] ? SUM_MAX
                                  : sum_wide[prsd_pkg::SUM_W-1:0];
                    count_next    = (count_reg == TICKS_MAX) ? count_reg
                                                             : count_reg + 1'b1;
                    was_meas_next = 1'b0;
                    period_next   = '0;
                    state_next    = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if ((window_reg > cfg.average_window_ticks) || (window_reg == TICKS_MAX))
                begin
                    res_next.average_done = 1'b1;
                    window_next           = '0;
                    if (count_reg == '0)
                    begin
                        avg_next               = '0;
                        res_next.average_empty = 1'b1;
                        sum_next               = '0;
                        state_next             = ST_OUT;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = sum_reg;
                        div_req.divisor  = prsd_pkg::DIVISOR_W'(count_reg);
                        div_req.steps    = prsd_pkg::AVG_DIV_STEPS;
                        state_next       = ST_AVG;
                    end
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = quo_sat;
                    sum_next   = '0;
                    count_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next             = res_reg;
                    out_next.average_bpm = avg_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= '0;
            period_reg    <= '0;
            was_meas_reg  <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            period_reg    <= period_next;
            was_meas_reg  <= was_meas_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            avg_reg       <= avg_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/pulse_rate_slope_detector_unit.sv =====
// top level of the pulse rate slope detector
//
//   channel  dir  beat contents
//   s_*      in   one sensor sample per tick
//   m_*      out  one result per tick
//   cfg_*    in   register index and write data
//
// front end takes one sample per cycle into a small fifo while it has room
// back end steps a plain tick through its idle, close and out states, and adds
// an 18-step rate division when a beat closes and a 32-step mean division when
// a window with beats closes; both divisions run on the shared divider
// m_tvalid holds with its data until m_tready; back end works on, then waits to hand over
// all control state clears on rst_n low; cfg_ready is always high
module pulse_rate_slope_detector_unit #(
    parameter int  SAMPLE_BITS = prsd_pkg::SAMPLE_BITS_DEFAULT,
    parameter int  QUEUE_DEPTH = prsd_pkg::QUEUE_DEPTH_DEFAULT,
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample [SAMPLE_BITS-1:0], zero fill above
    input  logic [IN_TDATA_W-1:0]             s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // led_on, beat_done, bpm[15:0], bpm_valid, average_done,
    // average_bpm[15:0], average_empty, zero fill above
    output logic [prsd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [prsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    prsd_pkg::cfg_t     cfg_reg, cfg_next;
    logic               push, queue_full, q_pop, q_not_empty;
    prsd_pkg::item_t    push_item, pop_item;
    prsd_pkg::div_req_t div_req;
    prsd_pkg::div_rsp_t div_rsp;
    prsd_pkg::result_t  result;

    assign cfg_ready = 1'b1;

    // register writes, unknown index ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (prsd_pkg::cfg_index_t'(cfg_index))
                prsd_pkg::REG_SLOPE_THRESHOLD:
                    cfg_next.slope_threshold = cfg_data[prsd_pkg::THRESH_W-1:0];
                prsd_pkg::REG_TICKS_PER_SECOND:
                    cfg_next.ticks_per_second = cfg_data[prsd_pkg::TPS_W-1:0];
                prsd_pkg::REG_MIN_VALID_BPM:
                    cfg_next.min_valid_bpm = cfg_data;
                prsd_pkg::REG_MAX_VALID_BPM:
                    cfg_next.max_valid_bpm = cfg_data;
                prsd_pkg::REG_AVERAGE_WINDOW_TICKS:
                    cfg_next.average_window_ticks = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slope_threshold      <= prsd_pkg::SLOPE_THRESHOLD_RST;
            cfg_reg.ticks_per_second     <= prsd_pkg::TICKS_PER_SECOND_RST;
            cfg_reg.min_valid_bpm        <= prsd_pkg::MIN_VALID_BPM_RST;
            cfg_reg.max_valid_bpm        <= prsd_pkg::MAX_VALID_BPM_RST;
            cfg_reg.average_window_ticks <= prsd_pkg::AVERAGE_WINDOW_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // slope classification
    prsd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .slope_threshold (cfg_reg.slope_threshold),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .sample          (s_tdata[SAMPLE_BITS-1:0]),
        .push            (push),
        .push_item       (push_item),
        .queue_full      (queue_full)
    );

    // decoupling fifo
    prsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    // counters, rate and mean
    prsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    // shared divider
    prsd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // result packing
    assign m_tdata = {(prsd_pkg::OUT_TDATA_W - prsd_pkg::OUT_FIELD_BITS)'(0), result};

endmodule

// ===== rtl/core/prsd_checker.sv =====
// port-level checks of the pulse rate slope detector and their binding
`include "pulse_rate_slope_detector_unit_macros.svh"

module prsd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [prsd_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    `PRSD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // rate fields only carry data on a beat
    `PRSD_ASSERT_NOW(a_bpm_on_beat, clk, rst_n, m_tvalid && !m_tdata[prsd_pkg::OUT_BEAT_DONE_BIT], m_tdata[prsd_pkg::OUT_BPM_LSB +: 16] == 16'd0 && !m_tdata[prsd_pkg::OUT_BPM_VALID_BIT])

    // empty window reports a zero mean on a window close
    `PRSD_ASSERT_NOW(a_empty_window, clk, rst_n, m_tvalid && m_tdata[prsd_pkg::OUT_AVERAGE_EMPTY_BIT], m_tdata[prsd_pkg::OUT_AVERAGE_DONE_BIT] && m_tdata[prsd_pkg::OUT_AVERAGE_BPM_LSB +: 16] == 16'd0)

    // a beat closes only once measuring has stopped
    `PRSD_ASSERT_NOW(a_beat_ends_period, clk, rst_n, m_tvalid && m_tdata[prsd_pkg::OUT_BEAT_DONE_BIT], !m_tdata[prsd_pkg::OUT_LED_ON_BIT])

endmodule

bind pulse_rate_slope_detector_unit prsd_checker u_prsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_pulse_rate_slope_detector_unit.sv =====
// self-checking stream testbench for the pulse rate slope detector unit
module tb_pulse_rate_slope_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import prsd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int SAMPLE_W         = SAMPLE_BITS_DEFAULT;
    localparam int IN_W             = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
    localparam int PHASES           = 9;
    localparam int DRAIN_CYCLES     = 100;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int SEND_IDLE_PCT    = 60;
    localparam int RECV_STALL_PCT   = 60;
    localparam int BOTH_IDLE_PCT    = 26;
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX = 3'd5;
    localparam logic [15:0] COUNT_SAT = 16'hFFFF;
    localparam logic [31:0] SUM_SAT   = 32'hFFFF_FFFF;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_W-1:0]        s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // stimulus and expected results
    logic [SAMPLE_W-1:0] sample_queue[$];
    result_t             expected_ticks[$];

    // idling control set by the sequence for driver and receiver, and the hold and watchdog counters
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        long_hold_armed = 1'b0;
    logic        long_hold_done;
    int unsigned hold_left;
    int unsigned quiet_cycles = 0;

    // run statistics
    int unsigned mismatches = 0;
    int unsigned samples_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned windows_seen = 0;
    int unsigned reg_writes = 0;

    // predictor copy of registers and state
    cfg_t rate_cfg = '{SLOPE_THRESHOLD_RST, TICKS_PER_SECOND_RST, MIN_VALID_BPM_RST,
                       MAX_VALID_BPM_RST, AVERAGE_WINDOW_TICKS_RST};
    logic [SAMPLE_W-1:0] last_sample = '0;
    logic                armed = 1'b0;
    logic                counting = 1'b0;
    logic                counted_before = 1'b0;
    logic [15:0]         period_len = '0;
    logic [15:0]         window_len = '0;
    logic [31:0]         rate_sum = '0;
    logic [15:0]         rate_count = '0;
    logic [15:0]         held_mean = '0;

    pulse_rate_slope_detector_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // one tick of the detector: slope test, period count, beat rate, window mean
    function automatic result_t predict_tick(logic [SAMPLE_W-1:0] smp);
        result_t         r;
        int              prev_v;
        int              smp_v;
        int              thr_v;
        longint unsigned num;
        longint unsigned rate;
        logic [31:0]     mean;
        r = '0;
        prev_v = int'(last_sample);
        smp_v = int'(smp);
        thr_v = int'(rate_cfg.slope_threshold);
        if (window_len != COUNT_SAT)
            window_len = window_len + 1'b1;

        // a rise arms, a fall while armed toggles the measuring flag
        if (prev_v + thr_v < smp_v)
            armed = 1'b1;
        else if (prev_v > smp_v + thr_v && armed)
        begin
            counting = !counting;
            armed = 1'b0;
        end
        last_sample = smp;

        // count the period, or close the beat on the first tick after it
        if (counting)
        begin
            counted_before = 1'b1;
            if (period_len != COUNT_SAT)
                period_len = period_len + 1'b1;
        end
        else if (counted_before)
        begin
            if (period_len == 0)
                rate = COUNT_SAT;
            else
            begin
                num = 64'(RATE_SCALE) * rate_cfg.ticks_per_second + period_len;
                rate = num / (64'd2 * period_len);
                if (rate > COUNT_SAT)
                    rate = COUNT_SAT;
            end
            r.beat_done = 1'b1;
            r.bpm = rate[15:0];
            r.bpm_valid = (rate >= rate_cfg.min_valid_bpm) && (rate <= rate_cfg.max_valid_bpm);
            if (rate_sum > SUM_SAT - rate)
                rate_sum = SUM_SAT;
            else
                rate_sum = rate_sum + rate[31:0];
            if (rate_count != COUNT_SAT)
                rate_count = rate_count + 1'b1;
            counted_before = 1'b0;
            period_len = '0;
        end

        // window close, after the beat of this tick has been summed
        if (window_len > rate_cfg.average_window_ticks || window_len == COUNT_SAT)
        begin
            r.average_done = 1'b1;
            if (rate_count == 0)
            begin
                held_mean = '0;
                r.average_empty = 1'b1;
            end
            else
            begin
                mean = rate_sum / rate_count;
                held_mean = (mean > COUNT_SAT) ? COUNT_SAT : mean[15:0];
            end
            rate_sum = '0;
            rate_count = '0;
            window_len = '0;
        end

        r.led_on = counting;
        r.average_bpm = held_mean;
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // sample driver, predicts each beat as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_ticks.push_back(predict_tick(s_tdata[SAMPLE_W-1:0]));
                samples_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tdata <= IN_W'(sample_queue.pop_front());
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver ready, with one long hold to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            long_hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (long_hold_armed && !long_hold_done)
        begin
            m_tready <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result monitor, compares each beat with the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[OUT_FIELD_BITS-1:0]);
            if (expected_ticks.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                check_field("led_on", want.led_on, got.led_on);
                check_field("beat_done", want.beat_done, got.beat_done);
                check_field("bpm", want.bpm, got.bpm);
                check_field("bpm_valid", want.bpm_valid, got.bpm_valid);
                check_field("average_done", want.average_done, got.average_done);
                check_field("average_bpm", want.average_bpm, got.average_bpm);
                check_field("average_empty", want.average_empty, got.average_empty);
            end
            if (got.beat_done)
                beats_seen++;
            if (got.average_done)
                windows_seen++;
        end
    end

    // watchdog on cycles with no beat moving anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // register write, predictor copy follows once the beat is taken
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SLOPE_THRESHOLD:      rate_cfg.slope_threshold = value[THRESH_W-1:0];
            REG_TICKS_PER_SECOND:     rate_cfg.ticks_per_second = value[TPS_W-1:0];
            REG_MIN_VALID_BPM:        rate_cfg.min_valid_bpm = value[RATE_W-1:0];
            REG_MAX_VALID_BPM:        rate_cfg.max_valid_bpm = value[RATE_W-1:0];
            REG_AVERAGE_WINDOW_TICKS: rate_cfg.average_window_ticks = value[TICKS_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // wait for every sample to be taken and every result to arrive,
    // checked on the falling edge once the driver has settled
    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_tvalid || expected_ticks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly clean pulses (flat gap, rise, fall), some noise and broken steps
    task automatic add_heartbeat_samples(int unsigned count);
        int unsigned goal;
        int unsigned thr;
        int unsigned amp;
        int unsigned base;
        int unsigned kind;
        goal = sample_queue.size() + count;
        thr = rate_cfg.slope_threshold;
        while (sample_queue.size() < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                amp = (thr >= SAMPLE_MAX) ? SAMPLE_MAX : $urandom_range(thr + 1, SAMPLE_MAX);
                base = $urandom_range(0, SAMPLE_MAX - amp);
                repeat ($urandom_range(0, 25))
                    sample_queue.push_back(SAMPLE_W'(base + $urandom_range(0, thr / 2)));
                sample_queue.push_back(SAMPLE_W'(base));
                sample_queue.push_back(SAMPLE_W'(base + amp));
                sample_queue.push_back(SAMPLE_W'(base));
            end
            else if (kind < 90 || thr >= SAMPLE_MAX)
            begin
                repeat ($urandom_range(1, 8))
                    sample_queue.push_back(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
            end
            else
            begin
                // steps of exactly the threshold count as neither rise nor fall
                base = $urandom_range(0, SAMPLE_MAX - thr);
                sample_queue.push_back(SAMPLE_W'(base));
                sample_queue.push_back(SAMPLE_W'(base + thr));
                sample_queue.push_back(SAMPLE_W'(base));
            end
        end
    endtask

    // reset, directed ticks, then register settings with random pulse trains
    initial
    begin
        logic [SAMPLE_W-1:0] directed[] = '{
            12'd4095, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd2048, 12'd2169,
            12'd2048, 12'd2168, 12'd2048, 12'd1928, 12'd2048, 12'd1927, 12'd2048,
            12'd4095, 12'd4095, 12'd0, 12'd0, 12'd1, 12'd4094, 12'd0};
        cfg_t       next_cfg;
        idle_mode_t mode;
        int         items;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first sample against zero, flat runs, steps at and just past the threshold
        foreach (directed[i])
            sample_queue.push_back(directed[i]);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            // settings: all-low extremes, all-high extremes, then random
            if (p == 0)
            begin
                next_cfg = '{12'd0, 10'd0, 16'd0, 16'd0, 16'd1};
                items = 200;
            end
            else if (p == 1)
            begin
                next_cfg = '{12'd4095, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                items = 60;
            end
            else
            begin
                next_cfg.slope_threshold = $urandom_range(0, 600);
                next_cfg.ticks_per_second = (p == 2) ? 10'd1023 : $urandom_range(1, 1000);
                next_cfg.min_valid_bpm = $urandom_range(0, 150);
                next_cfg.max_valid_bpm = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                     : $urandom_range(60, 400);
                next_cfg.average_window_ticks = $urandom_range(4, 250);
                items = 240;
            end
            write_register(REG_SLOPE_THRESHOLD,
                           {4'($urandom_range(0, 15)), next_cfg.slope_threshold});
            write_register(REG_TICKS_PER_SECOND,
                           {6'($urandom_range(0, 63)), next_cfg.ticks_per_second});
            write_register(REG_MIN_VALID_BPM, next_cfg.min_valid_bpm);
            write_register(REG_MAX_VALID_BPM, next_cfg.max_valid_bpm);
            write_register(REG_AVERAGE_WINDOW_TICKS, next_cfg.average_window_ticks);
            write_register(FIRST_UNUSED_INDEX + CFG_INDEX_W'($urandom_range(0, 2)),
                           CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;

            // idling pattern of this setting
            mode = (p == 0) ? IDLE_NONE : idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE:
                begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= 0;
                end
                IDLE_SENDER:
                begin
                    send_idle_pct <= SEND_IDLE_PCT;
                    recv_stall_pct <= 0;
                end
                IDLE_RECEIVER:
                begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= RECV_STALL_PCT;
                end
                default:
                begin
                    send_idle_pct <= BOTH_IDLE_PCT;
                    recv_stall_pct <= BOTH_IDLE_PCT;
                end
            endcase
            long_hold_armed <= (p == 0);

            add_heartbeat_samples(items);
            wait_drained();
        end

        if (expected_ticks.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_ticks.size());
            mismatches++;
        end

        $display("run covered %0d samples under %0d register writes", samples_sent, reg_writes);
        $display("closed %0d beats and %0d averaging windows, %0d mismatches",
                 beats_seen, windows_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
